FILE: rtl/core/tilt_pkg.sv
// Shared types, constants and the arctangent table for the accelerometer tilt block.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package tilt_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_LEN      = 24;
    localparam int CORDIC_RUN    = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
    localparam int ISQRT_STEPS   = 24;
    localparam int LANE_LAT      = 1 + ISQRT_STEPS + CORDIC_RUN + 1;
    localparam int TOTAL_LAT     = LANE_LAT + 1;

    localparam logic signed [16:0] RIGHT_ANGLE = 17'sd23040;

    // round(atan(2^-i) degrees * 65536)
    localparam logic [22:0] ATAN_TAB [0:ATAN_LEN-1] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
        23'd58666,   23'd29335,   23'd14668,  23'd7334,   23'd3667,   23'd1833,
        23'd917,     23'd458,     23'd229,    23'd115,    23'd57,     23'd29,
        23'd14,      23'd7,       23'd4,      23'd2,      23'd1,      23'd0
    };

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } tilt_in_t;

    typedef struct packed {
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
        logic signed [15:0] yaw_angle;
        logic               zero_sample;
    } tilt_out_t;

    // Per-lane sideband carried alongside the arithmetic.
    typedef struct packed {
        logic signed [15:0] axis;
        logic               axis_zero;
        logic               mag_zero;
    } tilt_side_t;

endpackage

FILE: rtl/core/tilt_isqrt.sv
// Pipelined floor square root, one result bit per stage, 48-bit radicand.
// Depends on tilt_pkg.
`timescale 1ns / 1ps

module tilt_isqrt (
    input  logic                clk,
    input  logic [47:0]         radicand,
    input  tilt_pkg::tilt_side_t side_in,
    output logic [23:0]         root,
    output tilt_pkg::tilt_side_t side_out
);
    import tilt_pkg::*;

    logic [27:0] rem_reg  [0:ISQRT_STEPS-1];
    logic [23:0] root_reg [0:ISQRT_STEPS-1];
    logic [47:0] rad_reg  [0:ISQRT_STEPS-1];
    tilt_side_t  side_reg [0:ISQRT_STEPS-1];

    for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_step
        logic [27:0] rem_in;
        logic [23:0] root_in;
        logic [47:0] rad_in;
        tilt_side_t  side_s;
        logic [27:0] rem_sh;
        logic [27:0] trial;
        logic        fits;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
            assign side_s  = side_in;
        end
        else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign side_s  = side_reg[k-1];
        end

        // bring down two radicand bits and try (root << 2) | 1
        assign rem_sh = {rem_in[25:0], rad_in[47:46]};
        assign trial  = {2'b00, root_in, 2'b01};
        assign fits   = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg[k] <= {root_in[22:0], fits};
            rad_reg[k]  <= {rad_in[45:0], 2'b00};
            side_reg[k] <= side_s;
        end
    end

    assign root     = root_reg[ISQRT_STEPS-1];
    assign side_out = side_reg[ISQRT_STEPS-1];

endmodule

FILE: rtl/core/tilt_lane.sv
// One tilt lane: squares, pipelined square root, vectoring CORDIC, round and clamp.
// Depends on tilt_pkg and tilt_isqrt.
`timescale 1ns / 1ps

module tilt_lane (
    input  logic               clk,
    input  logic signed [15:0] axis,
    input  logic signed [15:0] other_b,
    input  logic signed [15:0] other_c,
    output logic signed [15:0] angle
);
    import tilt_pkg::*;

    logic signed [31:0] prod_b;
    logic signed [31:0] prod_c;
    logic [30:0] sq_b_reg;
    logic [30:0] sq_c_reg;
    tilt_side_t  sq_side_reg;
    tilt_side_t  side_sq;
    logic [31:0] mag_sq;
    tilt_side_t  side_root;
    logic [23:0] root;
    tilt_side_t  side_in_sqrt;

    assign side_sq.axis      = axis;
    assign side_sq.axis_zero = (axis == 16'sd0);
    assign side_sq.mag_zero  = 1'b0;

    // full-width signed products; a square never exceeds 2^30
    assign prod_b = other_b * other_b;
    assign prod_c = other_c * other_c;

    always_ff @(posedge clk)
    begin
        sq_b_reg    <= prod_b[30:0];
        sq_c_reg    <= prod_c[30:0];
        sq_side_reg <= side_sq;
    end

    assign mag_sq = {1'b0, sq_b_reg} + {1'b0, sq_c_reg};

    always_comb
    begin
        side_in_sqrt          = sq_side_reg;
        side_in_sqrt.mag_zero = (mag_sq == 32'd0);
    end

    tilt_isqrt u_isqrt (
        .clk      (clk),
        .radicand ({mag_sq, 16'h0000}),
        .side_in  (side_in_sqrt),
        .root     (root),
        .side_out (side_root)
    );

    logic signed [27:0] x_reg [0:CORDIC_RUN-1];
    logic signed [27:0] y_reg [0:CORDIC_RUN-1];
    logic signed [24:0] z_reg [0:CORDIC_RUN-1];
    tilt_side_t         cs_reg [0:CORDIC_RUN-1];

    for (genvar i = 0; i < CORDIC_RUN; i++)
    begin : g_cordic
        logic signed [27:0] x_in;
        logic signed [27:0] y_in;
        logic signed [24:0] z_in;
        tilt_side_t         s_in;
        logic signed [27:0] dx;
        logic signed [27:0] dy;
        logic signed [24:0] step;

        if (i == 0)
        begin : g_first
            assign x_in = $signed({4'b0000, root});
            assign y_in = $signed({{4{side_root.axis[15]}}, side_root.axis, 8'h00});
            assign z_in = '0;
            assign s_in = side_root;
        end
        else
        begin : g_next
            assign x_in = x_reg[i-1];
            assign y_in = y_reg[i-1];
            assign z_in = z_reg[i-1];
            assign s_in = cs_reg[i-1];
        end

        assign dx   = y_in >>> i;
        assign dy   = x_in >>> i;
        assign step = $signed({2'b00, ATAN_TAB[i]});

        always_ff @(posedge clk)
        begin
            if (!y_in[27])
            begin
                x_reg[i] <= x_in + dx;
                y_reg[i] <= y_in - dy;
                z_reg[i] <= z_in + step;
            end
            else
            begin
                x_reg[i] <= x_in - dx;
                y_reg[i] <= y_in + dy;
                z_reg[i] <= z_in - step;
            end
            cs_reg[i] <= s_in;
        end
    end

    logic signed [24:0] z_round;
    logic signed [16:0] z_deg;
    logic signed [16:0] z_clamp;
    logic signed [15:0] angle_next;
    logic signed [15:0] angle_reg;
    tilt_side_t         s_last;

    assign s_last  = cs_reg[CORDIC_RUN-1];
    assign z_round = z_reg[CORDIC_RUN-1] + 25'sd128;
    assign z_deg   = z_round[24:8];

    always_comb
    begin
        if (z_deg > RIGHT_ANGLE)
            z_clamp = RIGHT_ANGLE;
        else if (z_deg < -RIGHT_ANGLE)
            z_clamp = -RIGHT_ANGLE;
        else
            z_clamp = z_deg;

        if (s_last.axis_zero)
            angle_next = '0;
        else if (s_last.mag_zero)
            angle_next = s_last.axis[15] ? 16'(-RIGHT_ANGLE) : 16'(RIGHT_ANGLE);
        else
            angle_next = z_clamp[15:0];
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
    end

    assign angle = angle_reg;

endmodule

FILE: rtl/core/accel_tilt_angles.sv
// Top level of the accelerometer tilt block: three tilt lanes and the merge register.
// Depends on tilt_pkg, tilt_lane and tilt_isqrt.
`timescale 1ns / 1ps

// Usage
//   Drive a raw three-axis sample on sample and raise start for one cycle; the
//   beat is taken at that edge. busy is always low, so a new sample can be
//   given on every cycle.
//   Each sample gives one result beat on result, marked by result_valid for
//   exactly one cycle, once it has passed the square register, the square-root
//   pipeline, the sixteen CORDIC stages, the angle register and the merge
//   register. Results leave in sample order. Throughput is one sample per
//   cycle: every lane is a full pipeline of squares, 24 square-root stages
//   and one CORDIC stage per rotation.
//   Reset clears the valid pipeline only; no result is shown until a new
//   sample has passed through. The receiver cannot stall the block: a result
//   beat that is not taken in its cycle is gone.
//   An all-zero sample gives zero angles with zero_sample set.
module accel_tilt_angles (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  tilt_pkg::tilt_in_t  sample,
    output logic                result_valid,
    output tilt_pkg::tilt_out_t result
);
    import tilt_pkg::*;

    logic               accept;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] yaw;
    logic               valid_reg [0:LANE_LAT-1];
    logic               zero_reg  [0:LANE_LAT-1];
    logic               out_valid_reg;
    tilt_out_t          out_reg;
    tilt_out_t          out_next;

    // never hold off the sender: every lane accepts a sample each cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    tilt_lane u_pitch (
        .clk     (clk),
        .axis    (sample.accel_x),
        .other_b (sample.accel_y),
        .other_c (sample.accel_z),
        .angle   (pitch)
    );

    tilt_lane u_roll (
        .clk     (clk),
        .axis    (sample.accel_y),
        .other_b (sample.accel_x),
        .other_c (sample.accel_z),
        .angle   (roll)
    );

    tilt_lane u_yaw (
        .clk     (clk),
        .axis    (sample.accel_z),
        .other_b (sample.accel_x),
        .other_c (sample.accel_y),
        .angle   (yaw)
    );

    // advance the valid marks in step with the lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < LANE_LAT; s++)
                valid_reg[s] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= accept;
            for (int s = 1; s < LANE_LAT; s++)
                valid_reg[s] <= valid_reg[s-1];
            out_valid_reg <= valid_reg[LANE_LAT-1];
        end
    end

    // hold the all-zero flag alongside
    always_ff @(posedge clk)
    begin
        zero_reg[0] <= (sample.accel_x == 16'sd0) && (sample.accel_y == 16'sd0)
                       && (sample.accel_z == 16'sd0);
        for (int s = 1; s < LANE_LAT; s++)
            zero_reg[s] <= zero_reg[s-1];
    end

    // merge the three lanes into one result beat
    always_comb
    begin
        out_next.pitch_angle = pitch;
        out_next.roll_angle  = roll;
        out_next.yaw_angle   = yaw;
        out_next.zero_sample = zero_reg[LANE_LAT-1];
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##TOTAL_LAT result_valid)
        else $error("result beat missing after sample");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.pitch_angle <= 16'sd23040 && result.pitch_angle >= -16'sd23040
                       && result.roll_angle <= 16'sd23040 && result.roll_angle >= -16'sd23040
                       && result.yaw_angle <= 16'sd23040 && result.yaw_angle >= -16'sd23040))
        else $error("angle out of range");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.zero_sample) |->
            (result.pitch_angle == 16'sd0 && result.roll_angle == 16'sd0
             && result.yaw_angle == 16'sd0))
        else $error("zero sample gave non-zero angle");
`endif

endmodule

FILE: tb/sv/tilt_checker.sv
// Checker for the tilt block: watches sample and result beats, predicts angles, compares.
// Depends on tilt_pkg for the beat types and the arctangent table.
`timescale 1ns / 1ps

module tilt_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  tilt_pkg::tilt_in_t  sample,
    input  logic                result_valid,
    input  tilt_pkg::tilt_out_t result,
    output int                  fail_count,
    output int                  pending
);
    import tilt_pkg::*;

    localparam int STAGE_CAP = 24;
    localparam int RUN_STAGES = (CORDIC_STAGES < STAGE_CAP) ? CORDIC_STAGES : STAGE_CAP;

    tilt_out_t angle_queue[$];

    assign pending = angle_queue.size();

    initial fail_count = 0;

    function automatic longint floor_sqrt(longint n);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = 64'd4294967296;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= n)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic logic signed [15:0] tilt_of(longint a, longint b, longint c);
        longint sq;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        sq = b * b + c * c;
        z = 0;
        if (sq == 0)
            return (a > 0) ? 16'sd23040 : ((a < 0) ? -16'sd23040 : 16'sd0);
        if (a == 0)
            return 16'sd0;
        x = floor_sqrt(sq * 65536);
        y = a * 256;
        for (int i = 0; i < RUN_STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end
            else
            begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end
        end
        z = (z + 128) >>> 8;
        if (z > 23040) z = 23040;
        if (z < -23040) z = -23040;
        return z[15:0];
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        tilt_out_t want;
        longint ax;
        longint ay;
        longint az;
        if (rst_n && start && !busy)
        begin
            ax = sample.accel_x;
            ay = sample.accel_y;
            az = sample.accel_z;
            want.pitch_angle = tilt_of(ax, ay, az);
            want.roll_angle  = tilt_of(ay, ax, az);
            want.yaw_angle   = tilt_of(az, ax, ay);
            want.zero_sample = (ax == 0 && ay == 0 && az == 0);
            angle_queue.push_back(want);
        end
        if (rst_n && result_valid)
        begin
            if (angle_queue.size() == 0)
            begin
                $display("%0t: result beat with no sample waiting", $time);
                fail_count++;
            end
            else
            begin
                want = angle_queue.pop_front();
                if (result.pitch_angle !== want.pitch_angle)
                    report("pitch", result.pitch_angle, want.pitch_angle);
                if (result.roll_angle !== want.roll_angle)
                    report("roll", result.roll_angle, want.roll_angle);
                if (result.yaw_angle !== want.yaw_angle)
                    report("yaw", result.yaw_angle, want.yaw_angle);
                if (result.zero_sample !== want.zero_sample)
                    report("zero_sample", result.zero_sample, want.zero_sample);
            end
        end
    end
endmodule

FILE: tb/sv/tb_top.sv
// Testbench top for accel_tilt_angles: clock, reset, sample stimulus and verdict.
// Depends on tilt_pkg, the block itself and tilt_checker.
`timescale 1ns / 1ps

module tb_top;
    import tilt_pkg::*;

    localparam int RANDOM_BEATS = 1130;
    localparam int CYCLE_LIMIT  = 200000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    tilt_in_t  sample = '0;
    logic      result_valid;
    tilt_out_t result;
    int        fail_count;
    int        pending;
    int        cycles = 0;

    always #6 clk = ~clk;

    accel_tilt_angles u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sample(sample), .result_valid(result_valid), .result(result)
    );

    tilt_checker u_check (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sample(sample),
        .result_valid(result_valid), .result(result),
        .fail_count(fail_count), .pending(pending)
    );

    // Abort on a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Pick an axis value: extremes, small values and zeros turn up often.
    function automatic logic [15:0] pick_axis();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'h7FFF;
            2: return 16'h8000;
            3: return 16'($signed($urandom_range(0, 16)) - 8);
            4: return 16'($signed($urandom_range(0, 512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    // Present one beat; hold start until it is taken, then leave start high
    // if the next beat follows back to back.
    task automatic send_beat(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        sample.accel_x <= x;
        sample.accel_y <= y;
        sample.accel_z <= z;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    // Drop start for a random gap: mostly none or short, now and then long.
    task automatic idle_gap();
        int gap;
        case ($urandom_range(0, 19))
            0:       gap = $urandom_range(20, 60);
            1, 2, 3, 4, 5: gap = $urandom_range(1, 4);
            default: gap = 0;
        endcase
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    initial
    begin
        logic [15:0] edges [5];
        edges = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000};
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: all-zero sample, single-axis samples, one axis zero, extremes.
        send_beat(16'h0000, 16'h0000, 16'h0000);
        for (int i = 1; i < 5; i++)
        begin
            send_beat(edges[i], 16'h0000, 16'h0000);
            send_beat(16'h0000, edges[i], 16'h0000);
            send_beat(16'h0000, 16'h0000, edges[i]);
        end
        send_beat(16'h0000, 16'h7FFF, 16'h8000);
        send_beat(16'h8000, 16'h8000, 16'h8000);
        send_beat(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_beat(16'h5555, 16'hAAAA, 16'h0001);
        send_beat(16'hAAAA, 16'h5555, 16'hFFFE);
        start <= 1'b0;
        repeat (3) @(negedge clk);

        // Random part; every few hundred beats run a stretch with no gaps.
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            send_beat(pick_axis(), pick_axis(), pick_axis());
            if ((n / 150) % 3 != 2)
                idle_gap();
        end
        start <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (TOTAL_LAT + 10) @(negedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
